>>> sv/dictcodec_pkg.sv
// Shared types, sizes and status codes for the dictionary encoder/decoder.
package dictcodec_pkg;

    // Table geometry
    localparam int DICT_DEPTH = 1024;
    localparam int IDX_W      = $clog2(DICT_DEPTH);
    localparam int CNT_W      = $clog2(DICT_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int STAT_W     = 3;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_DEC_HIT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEC_MISS = 3'd4;

    // Input word
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] code;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [STAT_W-1:0] status;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic              load_item;
        logic              clr_scan;
        logic              scan_rd;
        logic              dec_rd;
        logic              add_entry;
        logic              out_set;
        logic [STAT_W-1:0] out_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_dec;
        logic dec_hit;
        logic match;
        logic scan_done;
        logic full;
        logic out_free;
    } dp_sts_t;

endpackage

>>> sv/dictcodec_ctrl.sv
// Controller state machine sequencing encode scans and decode lookups.
module dictcodec_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  dictcodec_pkg::dp_sts_t sts,
    output dictcodec_pkg::dp_cmd_t cmd
);
    import dictcodec_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.is_dec)
                begin
                    if (sts.dec_hit)
                    begin
                        cmd.dec_rd = 1'b1;
                        state_next = S_DEC;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.out_set = 1'b1;
                        cmd.out_sel = ST_DEC_MISS;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    // hold the scan until the output register frees up
                    if (sts.out_free)
                    begin
                        cmd.out_set = 1'b1;
                        cmd.out_sel = ST_FOUND;
                        state_next  = S_IDLE;
                    end
                end
                else if (sts.scan_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_set   = 1'b1;
                        cmd.out_sel   = sts.full ? ST_FULL : ST_ADDED;
                        cmd.add_entry = !sts.full;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_DEC:
            begin
                if (sts.out_free)
                begin
                    cmd.out_set = 1'b1;
                    cmd.out_sel = ST_DEC_HIT;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dictcodec_dp.sv
// Datapath: item register, table memory, scan counter and output register.
module dictcodec_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dictcodec_pkg::in_word_t  item,
    input  dictcodec_pkg::dp_cmd_t   cmd,
    output dictcodec_pkg::dp_sts_t   sts,
    output logic                     res_valid,
    input  logic                     res_ready,
    output dictcodec_pkg::out_word_t res
);
    import dictcodec_pkg::*;

    logic [DATA_W-1:0] entries [DICT_DEPTH];

    in_word_t          item_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] rd_data_reg;
    out_word_t         out_reg;
    out_word_t         out_next;
    logic              out_valid_reg;

    logic              idx_lt_cnt;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  found_idx;

    assign idx_lt_cnt = (idx_reg < count_reg);
    assign found_idx  = idx_reg - CNT_W'(1);

    // Status towards the controller
    assign sts.is_dec    = (item_reg.op == OP_DECODE);
    assign sts.dec_hit   = (item_reg.code[DATA_W-1:CNT_W] == '0)
                           && (item_reg.code[CNT_W-1:0] < count_reg);
    assign sts.match     = pend_reg && (rd_data_reg == item_reg.value);
    assign sts.scan_done = !pend_reg && !idx_lt_cnt;
    assign sts.full      = (count_reg == CNT_W'(DICT_DEPTH));
    assign sts.out_free  = !out_valid_reg || res_ready;

    // Read port select
    assign rd_en   = (cmd.scan_rd && idx_lt_cnt) || cmd.dec_rd;
    assign rd_addr = cmd.dec_rd ? item_reg.code[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.add_entry)
        begin
            entries[count_reg[IDX_W-1:0]] <= item_reg.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries[rd_addr];
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
    end

    // Scan position, outstanding read flag and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.add_entry)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.clr_scan)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_rd)
            begin
                pend_reg <= idx_lt_cnt;
                if (idx_lt_cnt)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

    // Result word for the selected outcome
    always_comb
    begin
        out_next.status = cmd.out_sel;
        case (cmd.out_sel)
            ST_FOUND:    out_next.result = {{(DATA_W-CNT_W){1'b0}}, found_idx};
            ST_ADDED:    out_next.result = {{(DATA_W-CNT_W){1'b0}}, count_reg};
            ST_DEC_HIT:  out_next.result = rd_data_reg;
            ST_DEC_MISS: out_next.result = item_reg.code;
            default:     out_next.result = '0;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_set)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_set)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DICT_DEPTH))
        else $error("fill count beyond table depth");

    a_no_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_entry |-> !sts.full && sts.scan_done)
        else $error("entry appended to a full table or mid-scan");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_set |-> sts.out_free)
        else $error("result word overwritten before delivery");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_entry |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("fill count did not advance on append");

endmodule

>>> sv/dictionary_encoder_decoder_core.sv
// Top level: dictionary encoder/decoder with controller and datapath.
// Each word is handled on its own, and the next word is taken at the earliest
// on the edge where the previous result can be handed over. An encode word
// scans the table memory one entry per cycle through its single registered
// read port, over the used entries of the 1024-entry table; a match at index
// k ends the scan early. A decode word reads the stored entry when the code
// hits one, and passes the code through otherwise. A new word is accepted
// while the previous result still waits in the output register.
// The table starts empty after reset; no clearing pass is needed, as only
// filled entries are ever read.
module dictionary_encoder_decoder_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  dictcodec_pkg::in_word_t  item,
    output logic                     res_valid,
    input  logic                     res_ready,
    output dictcodec_pkg::out_word_t res
);
    import dictcodec_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    dictcodec_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    dictcodec_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

>>> tb/dictionary_encoder_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dictionary encoder/decoder core.
module dictionary_encoder_decoder_core_tb;
    import dictcodec_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     RST_CYCLES   = 7;
    localparam longint LIMIT_NS     = 64'd100_000_000;
    localparam int     DRAIN_CYCLES = 1100;
    localparam int     SEG_WORDS    = 40;
    localparam int     N_DIR        = 24;
    localparam int     SMALL_WORDS  = 120;
    localparam int     FILL_WORDS   = 336;
    localparam int     LATE_WORDS   = 100;
    localparam bit     TYPED        = 1'b1;
    localparam bit     MODEL        = 1'b0;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {GEN_SMALL, GEN_FILL, GEN_LATE} gen_phase_t;

    // One directed row: input word plus an optional hand-written result
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] code;
        logic              given;
        logic [DATA_W-1:0] exp_result;
        logic [STAT_W-1:0] exp_status;
    } dir_row_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_word_t  item       = '0;
    logic      res_valid;
    logic      res_ready  = 1'b0;
    out_word_t res;

    idle_mode_t  idle_mode  = IDLE_NONE;
    int          mismatches = 0;
    int          word_count = 0;
    out_word_t   pending_res [$];

    // Shadow copy of the dictionary
    logic [DATA_W-1:0] dict_mem [DICT_DEPTH];
    int unsigned       dict_used = 0;

    // Directed rows; the table is empty at the first row
    dir_row_t dir_tab [N_DIR] = '{
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0000, TYPED, 32'h0000_0000, ST_DEC_MISS},
        '{OP_DECODE, 32'h0000_0000, 32'hFFFF_FFFF, TYPED, 32'hFFFF_FFFF, ST_DEC_MISS},
        '{OP_ENCODE, 32'h0000_0000, 32'hFFFF_FFFF, TYPED, 32'h0000_0000, ST_ADDED},
        '{OP_ENCODE, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, 32'h0000_0001, ST_ADDED},
        '{OP_ENCODE, 32'h0000_0000, 32'h0000_0000, TYPED, 32'h0000_0000, ST_FOUND},
        '{OP_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, 32'h0000_0001, ST_FOUND},
        '{OP_DECODE, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, 32'h0000_0000, ST_DEC_HIT},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0001, TYPED, 32'hFFFF_FFFF, ST_DEC_HIT},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0002, TYPED, 32'h0000_0002, ST_DEC_MISS},
        '{OP_ENCODE, 32'h8000_0000, 32'h0000_0000, TYPED, 32'h0000_0002, ST_ADDED},
        '{OP_ENCODE, 32'h0000_0001, 32'h0000_0000, TYPED, 32'h0000_0003, ST_ADDED},
        '{OP_ENCODE, 32'h7FFF_FFFF, 32'h8000_0000, MODEL, 32'h0000_0000, ST_FOUND},
        '{OP_ENCODE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, MODEL, 32'h0000_0000, ST_FOUND},
        '{OP_ENCODE, 32'h5A5A_5A5A, 32'hA5A5_A5A5, MODEL, 32'h0000_0000, ST_FOUND},
        '{OP_DECODE, 32'h0000_0000, 32'h8000_0002, TYPED, 32'h8000_0002, ST_DEC_MISS},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0402, TYPED, 32'h0000_0402, ST_DEC_MISS},
        '{OP_DECODE, 32'h0000_0000, 32'h0001_0003, TYPED, 32'h0001_0003, ST_DEC_MISS},
        '{OP_ENCODE, 32'h8000_0000, 32'hFFFF_FFFF, TYPED, 32'h0000_0002, ST_FOUND},
        '{OP_DECODE, 32'hFFFF_FFFF, 32'h0000_0003, TYPED, 32'h0000_0001, ST_DEC_HIT},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0004, MODEL, 32'h0000_0000, ST_FOUND},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0006, MODEL, 32'h0000_0000, ST_FOUND},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0007, TYPED, 32'h0000_0007, ST_DEC_MISS},
        '{OP_DECODE, 32'h0000_0000, 32'h0000_0400, TYPED, 32'h0000_0400, ST_DEC_MISS},
        '{OP_ENCODE, 32'h5A5A_5A5A, 32'h0000_0000, MODEL, 32'h0000_0000, ST_FOUND}
    };

    dictionary_encoder_decoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Lowest index holding v, or -1
    function automatic int dict_find(input logic [DATA_W-1:0] v);
        for (int i = 0; i < dict_used; i++)
            if (dict_mem[i] == v)
                return i;
        return -1;
    endfunction

    // Work out the result of one word and update the shadow dictionary
    function automatic out_word_t dict_codec_predict(input in_word_t w);
        out_word_t r;
        int        hit;
        if (w.op == OP_ENCODE)
        begin
            hit = dict_find(w.value);
            if (hit >= 0)
            begin
                r.result = hit;
                r.status = ST_FOUND;
            end
            else if (dict_used >= DICT_DEPTH)
            begin
                r.result = '0;
                r.status = ST_FULL;
            end
            else
            begin
                dict_mem[dict_used] = w.value;
                r.result = dict_used;
                r.status = ST_ADDED;
                dict_used++;
            end
        end
        else if (w.code < dict_used)
        begin
            r.result = dict_mem[w.code];
            r.status = ST_DEC_HIT;
        end
        else
        begin
            r.result = w.code;
            r.status = ST_DEC_MISS;
        end
        return r;
    endfunction

    // Random value not yet in the dictionary
    function automatic logic [DATA_W-1:0] unseen_value();
        logic [DATA_W-1:0] v;
        v = $urandom;
        while (dict_find(v) >= 0)
            v = $urandom;
        return v;
    endfunction

    // Random word; the mix depends on how far the dictionary has grown
    function automatic in_word_t make_word(input gen_phase_t ph);
        in_word_t w;
        int       pick;
        w.op    = OP_ENCODE;
        w.value = $urandom;
        w.code  = $urandom;
        pick    = $urandom_range(99, 0);
        case (ph)
            GEN_SMALL:
            begin
                if (pick < 25)
                    w.value = unseen_value();
                else if (pick < 50)
                begin
                    if (dict_used != 0)
                        w.value = dict_mem[$urandom_range(dict_used - 1, 0)];
                end
                else
                begin
                    w.op = OP_DECODE;
                    if (pick < 80)
                        w.code = $urandom_range(dict_used + 2, 0);
                    else if (pick < 90)
                        // index-sized low bits under random upper bits
                        w.code = ($urandom & 32'hFFFF_FC00) | $urandom_range(dict_used, 0);
                end
            end
            GEN_FILL:
            begin
                if (pick < 85)
                    w.value = unseen_value();
                else if (pick < 92)
                    w.value = dict_mem[$urandom_range(dict_used - 1, 0)];
                else
                begin
                    w.op   = OP_DECODE;
                    w.code = $urandom_range(dict_used, 0);
                end
            end
            default:
            begin
                // repeats, new values and decodes, partly around the top used index
                if (pick < 30)
                    w.value = dict_mem[$urandom_range(dict_used - 1, 0)];
                else if (pick < 55)
                    w.value = unseen_value();
                else
                begin
                    w.op = OP_DECODE;
                    if (pick < 75)
                        w.code = $urandom_range(dict_used - 1, 0);
                    else if (pick < 85)
                        w.code = $urandom_range(dict_used + 2, dict_used - 3);
                end
            end
        endcase
        return w;
    endfunction

    // Offer one word, wait for acceptance, then queue its result
    task automatic send_word(input in_word_t w, input bit given, input out_word_t typed_res);
        int        gap;
        out_word_t pred;
        gap = 0;
        if (idle_mode == IDLE_SEND)
            while ($urandom_range(99, 0) < 83) gap++;
        else if (idle_mode == IDLE_BOTH)
            while ($urandom_range(99, 0) < 12) gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        pred = dict_codec_predict(w);
        pending_res.push_back(given ? typed_res : pred);
        word_count++;
    endtask

    task automatic send_random(input gen_phase_t ph);
        idle_mode = idle_mode_t'((word_count / SEG_WORDS) % 4);
        send_word(make_word(ph), MODEL, '0);
    endtask

    // Result side: random back-pressure and in-order comparison
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (pending_res.size() == 0)
                    report_mismatch($sformatf("unexpected word result=%h status=%0d",
                                              res.result, res.status));
                else
                begin
                    want = pending_res.pop_front();
                    if (res.result !== want.result)
                        report_mismatch($sformatf("result %h, wanted %h",
                                                  res.result, want.result));
                    if (res.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d (result %h)",
                                                  res.status, want.status, want.result));
                end
            end
            case (idle_mode)
                IDLE_RECV: res_ready <= ($urandom_range(99, 0) >= 83);
                IDLE_BOTH: res_ready <= ($urandom_range(99, 0) >= 12);
                default:   res_ready <= 1'b1;
            endcase
        end
    end

    initial
    begin : stimulus
        in_word_t  w;
        out_word_t typed_res;
        rst_n = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; second half with light idling on both sides
        for (int i = 0; i < N_DIR; i++)
        begin
            idle_mode        = (i < N_DIR / 2) ? IDLE_NONE : IDLE_BOTH;
            w.op             = dir_tab[i].op;
            w.value          = dir_tab[i].value;
            w.code           = dir_tab[i].code;
            typed_res.result = dir_tab[i].exp_result;
            typed_res.status = dir_tab[i].exp_status;
            send_word(w, dir_tab[i].given, typed_res);
        end

        // Small table: plenty of hits, misses and repeats
        repeat (SMALL_WORDS) send_random(GEN_SMALL);
        // Grow the table
        repeat (FILL_WORDS) send_random(GEN_FILL);
        // Larger table: repeats, new values, decodes partly around the top index
        repeat (LATE_WORDS) send_random(GEN_LATE);

        item_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        idle_mode = IDLE_NONE;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("** dictionary_encoder_decoder_core: PASSED **");
        else
            $display("** dictionary_encoder_decoder_core: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("** dictionary_encoder_decoder_core: FAILED **");
        $finish;
    end

endmodule

>>> dictionary_encoder_decoder_core.f
sv/dictcodec_pkg.sv
sv/dictcodec_ctrl.sv
sv/dictcodec_dp.sv
sv/dictionary_encoder_decoder_core.sv
tb/dictionary_encoder_decoder_core_tb.sv
